[src/sas_pkg.sv]
`default_nettype none
package sas_pkg;
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic [30:0]        sphere_radius;
    } t_arc_in;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               is_last;
    } t_arc_out;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       load;
        logic       mid_go;
        logic [6:0] idx_a;
        logic [6:0] idx_b;
        logic [6:0] idx_d;
        logic       rd_go;
        logic [6:0] idx_r;
        logic       last;
    } t_sas_cmd;

    typedef struct packed {
        logic mid_done;
    } t_sas_stat;
endpackage
`default_nettype wire

[src/sas_datapath.sv]
`default_nettype none
module sas_datapath
    import sas_pkg::*;
#(
    parameter int LEVELS = 6
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_arc_in   i_item,
    input  wire t_sas_cmd  i_cmd,
    output t_sas_stat      o_stat,
    output t_arc_out       o_result,
    output logic           o_result_valid
);
    localparam int Span = 1 << LEVELS;
    localparam int Ab = LEVELS + 1;

    logic signed [31:0] mem_x [0:Span];
    logic signed [31:0] mem_y [0:Span];
    logic signed [31:0] mem_z [0:Span];

    typedef enum logic [3:0] {
        D_IDLE, D_RDA, D_RDB, D_SUM, D_NORM, D_SQ, D_SQRT, D_DIVSET, D_DIV, D_SAT, D_WR
    } t_dstate;
    t_dstate r_st;

    logic signed [31:0] r_rx, r_ry, r_rz;
    logic signed [33:0] r_s [0:2];
    logic [30:0] r_rad;
    logic [6:0] r_dst;
    logic [6:0] r_idx_b;
    logic [5:0] r_cnt;
    logic [1:0] r_k;
    logic [65:0] r_q;
    logic [65:0] r_sqv, r_res, r_bit;
    logic [63:0] r_num, r_rem, r_quo;
    logic [31:0] r_n;
    logic signed [31:0] r_out [0:2];
    logic r_wr_en;
    logic [6:0] r_wr_idx;
    logic signed [31:0] r_wx, r_wy, r_wz;
    logic r_rd_pend, r_rd_last;
    logic r_rd_pend2, r_rd_last2;
    logic [6:0] r_mem_addr;
    logic r_load2;
    logic signed [31:0] r_ex, r_ey, r_ez;

    logic [33:0] mag0, mag1, mag2, magmax;
    logic [33:0] mk;
    logic [65:0] sqtry;
    logic [64:0] remsh;
    logic [63:0] rr;

    always_comb begin
        mag0 = r_s[0][33] ? 34'(-r_s[0]) : 34'(r_s[0]);
        mag1 = r_s[1][33] ? 34'(-r_s[1]) : 34'(r_s[1]);
        mag2 = r_s[2][33] ? 34'(-r_s[2]) : 34'(r_s[2]);
        magmax = mag0;
        if (mag1 > magmax) magmax = mag1;
        if (mag2 > magmax) magmax = mag2;
        case (r_k)
            2'd0: mk = mag0;
            2'd1: mk = mag1;
            default: mk = mag2;
        endcase
        sqtry = r_res + r_bit;
        remsh = {r_rem, r_num[63]};
        rr = r_quo;
    end

    // Memory ports: one write, one read address per cycle.
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            mem_x[Ab'(r_wr_idx)] <= r_wx;
            mem_y[Ab'(r_wr_idx)] <= r_wy;
            mem_z[Ab'(r_wr_idx)] <= r_wz;
        end
        r_rx <= mem_x[Ab'(r_mem_addr)];
        r_ry <= mem_y[Ab'(r_mem_addr)];
        r_rz <= mem_z[Ab'(r_mem_addr)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= D_IDLE;
            r_wr_en <= 1'b0;
            r_rd_pend <= 1'b0;
            r_rd_pend2 <= 1'b0;
            o_result_valid <= 1'b0;
            o_stat <= '0;
        end else begin
            r_wr_en <= 1'b0;
            o_stat.mid_done <= 1'b0;
            // Valid follows rd_go through r_rd_pend, r_rd_pend2.
            o_result_valid <= r_rd_pend2;
            o_result <= '{point_x: r_rx, point_y: r_ry, point_z: r_rz, is_last: r_rd_last2};
            r_rd_pend <= i_cmd.rd_go;
            r_rd_last <= i_cmd.last;
            r_rd_pend2 <= r_rd_pend;
            r_rd_last2 <= r_rd_last;
            if (i_cmd.rd_go) r_mem_addr <= i_cmd.idx_r;
            if (i_cmd.load) begin
                r_rad <= i_item.sphere_radius;
            end
            case (r_st)
                D_IDLE: begin
                    if (i_cmd.mid_go) begin
                        r_mem_addr <= i_cmd.idx_a;
                        r_dst <= i_cmd.idx_d;
                        r_idx_b <= i_cmd.idx_b;
                        r_st <= D_RDA;
                    end
                end
                D_RDA: begin
                    r_mem_addr <= r_idx_b;
                    r_st <= D_RDB;
                end
                D_RDB: begin
                    r_s[0] <= 34'(r_rx);
                    r_s[1] <= 34'(r_ry);
                    r_s[2] <= 34'(r_rz);
                    r_st <= D_SUM;
                end
                D_SUM: begin
                    r_s[0] <= r_s[0] + 34'(r_rx);
                    r_s[1] <= r_s[1] + 34'(r_ry);
                    r_s[2] <= r_s[2] + 34'(r_rz);
                    r_st <= D_NORM;
                end
                D_NORM: begin
                    if (magmax == '0) begin
                        r_out[0] <= '0; r_out[1] <= '0; r_out[2] <= '0;
                        r_st <= D_WR;
                    end else if (magmax >= 34'd2147483648) begin
                        // Halving truncates toward zero.
                        for (int k = 0; k < 3; k++)
                            r_s[k] <= (r_s[k] + $signed({33'd0, r_s[k][33]})) >>> 1;
                    end else if (magmax < 34'd1073741824) begin
                        for (int k = 0; k < 3; k++) r_s[k] <= r_s[k] <<< 1;
                    end else begin
                        r_q <= '0;
                        r_k <= 2'd0;
                        r_st <= D_SQ;
                    end
                end
                D_SQ: begin
                    r_q <= r_q + 66'(mk[31:0] * mk[31:0]);
                    if (r_k == 2'd2) begin
                        r_st <= D_SQRT;
                        r_sqv <= '0;
                        r_res <= '0;
                        r_bit <= 66'h1 << 64;
                        r_cnt <= 6'd0;
                    end
                    r_k <= r_k + 2'd1;
                end
                D_SQRT: begin
                    if (r_cnt == 6'd0) begin
                        r_sqv <= r_q;
                        r_cnt <= 6'd1;
                    end else if (r_bit == '0) begin
                        r_n <= (r_res == '0) ? 32'd1 : r_res[31:0];
                        r_k <= 2'd0;
                        r_st <= D_DIVSET;
                    end else begin
                        if (r_sqv >= sqtry) begin
                            r_sqv <= r_sqv - sqtry;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                D_DIVSET: begin
                    r_num <= 64'(mk[31:0] * 32'(r_rad)) + 64'(r_n >> 1);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= 6'd0;
                    r_st <= D_DIV;
                end
                D_DIV: begin
                    if (remsh >= 65'(r_n)) begin
                        r_rem <= 64'(remsh - 65'(r_n));
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= remsh[63:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) r_st <= D_SAT;
                end
                D_SAT: begin
                    if (r_s[r_k][33])
                        r_out[r_k] <= (rr > 64'h80000000) ? 32'sh80000000 : -32'(rr);
                    else
                        r_out[r_k] <= (rr > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(rr);
                    if (r_k == 2'd2) r_st <= D_WR;
                    else begin
                        r_k <= r_k + 2'd1;
                        r_st <= D_DIVSET;
                    end
                end
                D_WR: begin
                    r_wr_en <= 1'b1;
                    r_wr_idx <= r_dst;
                    r_wx <= r_out[0]; r_wy <= r_out[1]; r_wz <= r_out[2];
                    o_stat.mid_done <= 1'b1;
                    r_st <= D_IDLE;
                end
                default: r_st <= D_IDLE;
            endcase
            if (i_cmd.load) begin
                r_wr_en <= 1'b1;
                r_wr_idx <= '0;
                r_wx <= i_item.start_x; r_wy <= i_item.start_y; r_wz <= i_item.start_z;
            end
            // End point goes in the cycle after the start point.
            if (r_load2) begin
                r_wr_en <= 1'b1;
                r_wr_idx <= 7'(Span);
                r_wx <= r_ex; r_wy <= r_ey; r_wz <= r_ez;
            end
            if (r_st == D_IDLE && !i_cmd.mid_go && !i_cmd.load && !i_cmd.rd_go
                && r_cnt == 6'd62) begin
                r_cnt <= 6'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_load2 <= 1'b0;
        else r_load2 <= i_cmd.load;
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ex <= i_item.end_x; r_ey <= i_item.end_y; r_ez <= i_item.end_z;
        end
    end
endmodule
`default_nettype wire

[src/sas_control.sv]
`default_nettype none
module sas_control
    import sas_pkg::*;
#(
    parameter int LEVELS = 6
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_sas_stat i_stat,
    output t_sas_cmd       o_cmd,
    output logic           o_busy
);
    localparam int Span = 1 << LEVELS;

    typedef enum logic [2:0] {S_IDLE, S_SETUP, S_MID, S_WAIT, S_OUT} t_state;
    t_state r_state;
    logic [7:0] r_span;
    logic [7:0] r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_cmd <= '0;
            o_busy <= 1'b0;
            r_span <= '0;
            r_i <= '0;
        end else begin
            o_cmd <= '0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        o_cmd.load <= 1'b1;
                        o_busy <= 1'b1;
                        r_span <= 8'(Span);
                        r_i <= 8'(Span / 2);
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: r_state <= S_MID;
                S_MID: begin
                    o_cmd.mid_go <= 1'b1;
                    o_cmd.idx_a <= 7'(r_i - (r_span >> 1));
                    o_cmd.idx_b <= 7'(r_i + (r_span >> 1));
                    o_cmd.idx_d <= 7'(r_i);
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_stat.mid_done) begin
                        if (r_i + r_span < 8'(Span)) begin
                            r_i <= r_i + r_span;
                            r_state <= S_MID;
                        end else if (r_span > 8'd2) begin
                            r_span <= r_span >> 1;
                            r_i <= r_span >> 2;
                            r_state <= S_MID;
                        end else begin
                            r_i <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    o_cmd.rd_go <= 1'b1;
                    o_cmd.idx_r <= 7'(r_i);
                    o_cmd.last <= (r_i == 8'(Span - 1));
                    r_i <= r_i + 8'd1;
                    if (r_i == 8'(Span - 1)) begin
                        o_busy <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/sphere_arc_subdivider_unit.sv]
`default_nettype none
// Subdivides the great arc between two points into 2^LEVELS steps by repeated
// midpoint insertion and emits the start point followed by every interior
// point, one per strobe, the last one flagged. Each inserted point is rescaled
// by single-bit normalizing shifts (up to 30), a 33-step square root and three
// 64-step restoring divides sharing one unit. Once every midpoint is written,
// results stream at one per cycle; the receiver cannot stall them.
module sphere_arc_subdivider_unit
    import sas_pkg::*;
#(
    parameter int LEVELS = 6
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_arc_in i_item,
    output t_arc_out     o_result,
    output logic         o_result_strobe
);
    t_sas_cmd  cmd;
    t_sas_stat stat;
    logic      busy_r;

    sas_control #(.LEVELS(LEVELS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy_r)
    );

    sas_datapath #(.LEVELS(LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(cmd),
        .o_stat(stat), .o_result(o_result), .o_result_valid(o_result_strobe)
    );

    // Busy covers the tail of the reads through r_tail, but drops in the cycle the last result is strobed.
    logic [1:0] r_tail;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tail <= '0;
        else r_tail <= {r_tail[0], cmd.rd_go};
    end
    assign busy = busy_r || (|r_tail) || cmd.rd_go;

`ifndef ASSERT_OFF
    a_no_start_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy || $past(busy)) else $error("strobe outside arc");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.is_last) |=> !o_result_strobe)
        else $error("result after last");
`endif
endmodule
`default_nettype wire

[tb/tb_sphere_arc_subdivider_unit.sv]
`default_nettype none
module tb_sphere_arc_subdivider_unit;
    import sas_pkg::*;

    localparam int LEVELS   = 6;
    localparam int ARC_SPAN = 1 << LEVELS;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_arc_in  i_item;
    t_arc_out o_result;
    logic     o_result_strobe;

    sphere_arc_subdivider_unit #(.LEVELS(LEVELS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_result(o_result),
        .o_result_strobe(o_result_strobe)
    );

    t_arc_in  pending_arcs[$];
    t_arc_out arc_points_due[$];
    bit       pause_marks[$];
    longint   px[ARC_SPAN + 1];
    longint   py[ARC_SPAN + 1];
    longint   pz[ARC_SPAN + 1];
    int       mismatches;
    int       arcs_sent;
    int       arcs_total;
    int       points_seen;
    int       zero_mids;
    int       clamped_mids;
    bit       draining;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Inserts the rescaled midpoint of positions a and b at position d.
    task automatic insert_midpoint(int a, int b, int d, longint radius);
        longint s[3];
        longint res[3];
        longint unsigned m;
        longint unsigned q;
        longint unsigned n;
        longint unsigned r;
        s[0] = px[a] + px[b];
        s[1] = py[a] + py[b];
        s[2] = pz[a] + pz[b];
        m = 0;
        for (int k = 0; k < 3; k++) if (magnitude(s[k]) > m) m = magnitude(s[k]);
        if (m == 0) begin
            px[d] = 0;
            py[d] = 0;
            pz[d] = 0;
            zero_mids++;
            return;
        end
        while (m >= (64'd1 << 31)) begin
            for (int k = 0; k < 3; k++) s[k] = s[k] / 2;
            m >>= 1;
        end
        while (m < (64'd1 << 30)) begin
            for (int k = 0; k < 3; k++) s[k] = s[k] * 2;
            m <<= 1;
        end
        q = 0;
        for (int k = 0; k < 3; k++) q += magnitude(s[k]) * magnitude(s[k]);
        n = int_sqrt(q);
        if (n == 0) n = 1;
        for (int k = 0; k < 3; k++) begin
            r = (magnitude(s[k]) * longint'(radius) + (n >> 1)) / n;
            if (s[k] < 0) begin
                if (r > longint'(COORD_MAX) + 1) begin
                    res[k] = COORD_MIN;
                    clamped_mids++;
                end else begin
                    res[k] = -longint'(r);
                end
            end else begin
                if (r > longint'(COORD_MAX)) begin
                    res[k] = COORD_MAX;
                    clamped_mids++;
                end else begin
                    res[k] = longint'(r);
                end
            end
        end
        px[d] = res[0];
        py[d] = res[1];
        pz[d] = res[2];
    endtask

    task automatic predict_arc(t_arc_in arc);
        t_arc_out pt;
        longint radius;
        radius = longint'({33'd0, arc.sphere_radius});
        px[0] = arc.start_x;
        py[0] = arc.start_y;
        pz[0] = arc.start_z;
        px[ARC_SPAN] = arc.end_x;
        py[ARC_SPAN] = arc.end_y;
        pz[ARC_SPAN] = arc.end_z;
        for (int span = ARC_SPAN; span >= 2; span >>= 1)
            for (int i = span / 2; i < ARC_SPAN; i += span)
                insert_midpoint(i - span / 2, i + span / 2, i, radius);
        for (int i = 0; i < ARC_SPAN; i++) begin
            pt.point_x = px[i][31:0];
            pt.point_y = py[i][31:0];
            pt.point_z = pz[i][31:0];
            pt.is_last = (i == ARC_SPAN - 1);
            arc_points_due = {arc_points_due, pt};
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at point %0d: %s got %0d expected %0d",
                 points_seen, what, got, want);
        mismatches++;
    endtask

    // Driver: a transfer happens at an edge with start high and busy low.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_arc(i_item);
                arcs_sent++;
                start <= 1'b0;
            end else if (!start && pending_arcs.size() != 0) begin
                if (draining) begin
                    if (arc_points_due.size() == 0) draining <= 1'b0;
                end else if (pause_marks[0] && arc_points_due.size() != 0) begin
                    draining <= 1'b1;
                end else if ((arcs_sent >= 60 && arcs_sent < 100)
                             || $urandom_range(99) >= 27) begin
                    i_item <= pending_arcs.pop_front();
                    void'(pause_marks.pop_front());
                    start <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_arc_out want;
        if (i_rst_n && o_result_strobe) begin
            if (arc_points_due.size() == 0) begin
                report_mismatch("unexpected point_x", o_result.point_x, 0);
            end else begin
                want = arc_points_due.pop_front();
                if (o_result.point_x !== want.point_x)
                    report_mismatch("point_x", o_result.point_x, want.point_x);
                if (o_result.point_y !== want.point_y)
                    report_mismatch("point_y", o_result.point_y, want.point_y);
                if (o_result.point_z !== want.point_z)
                    report_mismatch("point_z", o_result.point_z, want.point_z);
                if (o_result.is_last !== want.is_last)
                    report_mismatch("is_last", o_result.is_last, want.is_last);
            end
            points_seen++;
        end
    end

    task automatic queue_arc(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                             logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                             logic [30:0] rad, bit pause);
        t_arc_in arc;
        arc.start_x = sx;
        arc.start_y = sy;
        arc.start_z = sz;
        arc.end_x = ex;
        arc.end_y = ey;
        arc.end_z = ez;
        arc.sphere_radius = rad;
        pending_arcs = {pending_arcs, arc};
        pause_marks = {pause_marks, pause};
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        int mode;
        mismatches = 0;
        arcs_sent = 0;
        points_seen = 0;
        zero_mids = 0;
        clamped_mids = 0;
        draining = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;

        // Unit axes on a unit sphere, quarter and half turns.
        queue_arc(32'h10000, 0, 0, 0, 32'h10000, 0, 31'h10000, 1'b0);
        queue_arc(32'h10000, 0, 0, 32'hFFFF0000, 0, 0, 31'h10000, 1'b0);
        // Opposite points give a zero sum on the first midpoint.
        queue_arc(32'h7FFFFFFF, 32'h80000001, 5, 32'h80000001, 32'h7FFFFFFF, -5,
                  31'h7FFFFFFF, 1'b1);
        // Both endpoints zero.
        queue_arc(0, 0, 0, 0, 0, 0, 31'h12345, 1'b0);
        // Extremes of every coordinate with the largest radius.
        queue_arc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
        queue_arc(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
        queue_arc(32'h80000000, 0, 0, 0, 32'h80000000, 0, 31'h7FFFFFFF, 1'b1);
        // Zero radius, tiny vectors and identical endpoints.
        queue_arc(32'h7FFFFFFF, 1, 0, 1, 32'h7FFFFFFF, 0, 31'h0, 1'b0);
        queue_arc(1, 0, 0, 0, 0, 1, 31'h1, 1'b0);
        queue_arc(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 1'b0);
        queue_arc(32'h00030000, 32'hFFFC0000, 32'h0, 32'h00030000, 32'hFFFC0000,
                  32'h0, 31'h50000, 1'b0);
        queue_arc(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                  32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 1'b1);
        queue_arc(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0,
                  32'h13579BDF, 32'h2468ACE0, 31'h55555555, 1'b0);

        for (int i = 0; i < 190; i++) begin
            mode = $urandom_range(2);
            if ($urandom_range(9) == 0) begin
                a = rand_coord(mode);
                b = rand_coord(mode);
                c = rand_coord(mode);
                queue_arc(a, b, c, -a, -b, -c, 31'($urandom()), 1'b0);
            end else begin
                queue_arc(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                          rand_coord(mode), rand_coord(mode), rand_coord(mode),
                          ($urandom_range(3) == 0) ? 31'($urandom())
                                                   : 31'($urandom_range(32'h0100_0000)),
                          i == 95);
            end
        end
        arcs_total = pending_arcs.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (arcs_sent == arcs_total);
        wait (arc_points_due.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d arcs checked over %0d points, from axis turns to full-scale",
                 arcs_sent, points_seen);
        $display("%0d zero-sum midpoints and %0d clamped coordinates seen",
                 zero_mids, clamped_mids);
        if (mismatches == 0) begin
            $display("PASS sphere_arc_subdivider_unit");
        end else begin
            $display("FAIL sphere_arc_subdivider_unit");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("FAIL sphere_arc_subdivider_unit");
        $finish;
    end
endmodule
`default_nettype wire

[sphere_arc_subdivider_unit.f]
src/sas_pkg.sv
src/sas_datapath.sv
src/sas_control.sv
src/sphere_arc_subdivider_unit.sv
tb/tb_sphere_arc_subdivider_unit.sv
